>>> rtl/ksrs_pkg.sv
// Shared types, codes and default sizes for the key set range sum core.
package ksrs_pkg;

   localparam int DEF_MAX_KEYS = 1024;
   localparam int DEF_KEY_BITS = 30;
   localparam int SUM_BITS     = 40;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_QUERY  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   // Controls from the sequencer to the shared compare/accumulate unit.
   typedef struct packed {
      logic clear;
      logic step;
      logic query;
   } scan_ctrl_type;

endpackage

>>> rtl/ksrs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ksrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ksrs_scan_unit.sv
// Shared compare and accumulate unit applied to one stored key per cycle while step is set.
module ksrs_scan_unit #(
   parameter int KEY_BITS = ksrs_pkg::DEF_KEY_BITS
) (
   input  logic                          clock,
   input  ksrs_pkg::scan_ctrl_type       ctrl,
   input  logic [KEY_BITS-1:0]           entry,
   input  logic [KEY_BITS-1:0]           key,
   input  logic [KEY_BITS-1:0]           range_low,
   input  logic [KEY_BITS-1:0]           range_high,
   output logic [ksrs_pkg::SUM_BITS-1:0] sum,
   output logic                          hit
);

   localparam int EXT_BITS = ksrs_pkg::SUM_BITS + KEY_BITS;

   logic [ksrs_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic                          hit_ff, hit_in;
   logic [EXT_BITS-1:0]           entry_ext;
   logic                          in_range;

   // Zero-extend then cut to the sum width; wraps if keys are wider.
   assign entry_ext = {{ksrs_pkg::SUM_BITS{1'b0}}, entry};
   assign in_range  = (entry >= range_low) && (entry <= range_high);

   always_comb begin
      sum_in = sum_ff;
      hit_in = hit_ff;
      if (ctrl.clear) begin
         sum_in = '0;
         hit_in = 1'b0;
      end else if (ctrl.step) begin
         if (ctrl.query) begin
            if (in_range) begin
               sum_in = sum_ff + entry_ext[ksrs_pkg::SUM_BITS-1:0];
            end
         end else if (entry == key) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      hit_ff <= hit_in;
   end

   assign sum = sum_ff;
   assign hit = hit_ff;

endmodule

>>> rtl/key_set_range_sum_core.sv
// Key set with range sum: a sequencer scans the key RAM through one shared unit.
// Sequence: IDLE, then SCAN over every stored entry, DRAIN and FINISH; an empty store
//   goes from IDLE straight to FINISH. The result is registered out of FINISH.
// Requests: a new one is taken only in IDLE, after the previous one is through.
// Reset: synchronous; clears the entry count and the sequencer. Key RAM is not cleared,
//   only entries below the count are ever read. The receiver cannot stall the result.
module key_set_range_sum_core #(
   parameter int MAX_KEYS = ksrs_pkg::DEF_MAX_KEYS,
   parameter int KEY_BITS = ksrs_pkg::DEF_KEY_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [KEY_BITS-1:0]           req_key,
   input  logic [KEY_BITS-1:0]           req_range_low,
   input  logic [KEY_BITS-1:0]           req_range_high,
   output logic                          rsp_valid,
   output logic [ksrs_pkg::SUM_BITS-1:0] rsp_range_sum,
   output logic [1:0]                    rsp_status
);

   localparam int ADDR_W = $clog2(MAX_KEYS);
   localparam int CNT_W  = $clog2(MAX_KEYS + 1);

   ksrs_pkg::state_type           state_ff, state_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          data_vld_ff, data_vld_in;
   ksrs_pkg::command_type         cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]           key_ff, key_in;
   logic [KEY_BITS-1:0]           low_ff, low_in;
   logic [KEY_BITS-1:0]           high_ff, high_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ksrs_pkg::SUM_BITS-1:0] rsp_sum_ff, rsp_sum_in;
   ksrs_pkg::status_type          rsp_status_ff, rsp_status_in;

   ksrs_pkg::scan_ctrl_type       scan_ctrl;
   logic                          wr_en;
   logic [KEY_BITS-1:0]           rd_data;
   logic [ksrs_pkg::SUM_BITS-1:0] scan_sum;
   logic                          scan_hit;

   ksrs_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (MAX_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (key_ff),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   ksrs_scan_unit #(
      .KEY_BITS (KEY_BITS)
   ) u_scan (
      .clock      (clock),
      .ctrl       (scan_ctrl),
      .entry      (rd_data),
      .key        (key_ff),
      .range_low  (low_ff),
      .range_high (high_ff),
      .sum        (scan_sum),
      .hit        (scan_hit)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      data_vld_in   = 1'b0;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      rsp_valid_in  = 1'b0;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      scan_ctrl     = '{clear: 1'b0, step: data_vld_ff, query: (cmd_ff == ksrs_pkg::CMD_QUERY)};

      unique case (state_ff)
         ksrs_pkg::S_IDLE: begin
            if (start) begin
               cmd_in          = ksrs_pkg::command_type'(req_command);
               key_in          = req_key;
               low_in          = req_range_low;
               high_in         = req_range_high;
               idx_in          = '0;
               scan_ctrl.clear = 1'b1;
               if (count_ff == '0) begin
                  state_in = ksrs_pkg::S_FINISH;
               end else begin
                  state_in = ksrs_pkg::S_SCAN;
               end
            end
         end
         ksrs_pkg::S_SCAN: begin
            // Read issued at idx_ff; its data reaches the unit next cycle.
            data_vld_in = 1'b1;
            idx_in      = idx_ff + CNT_W'(1);
            if (idx_in == count_ff) begin
               state_in = ksrs_pkg::S_DRAIN;
            end
         end
         ksrs_pkg::S_DRAIN: begin
            state_in = ksrs_pkg::S_FINISH;
         end
         ksrs_pkg::S_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = ksrs_pkg::S_IDLE;
            if (cmd_ff == ksrs_pkg::CMD_QUERY) begin
               rsp_sum_in    = scan_sum;
               rsp_status_in = ksrs_pkg::ST_DONE;
            end else begin
               rsp_sum_in = '0;
               priority if (scan_hit) begin
                  rsp_status_in = ksrs_pkg::ST_DUP;
               end else if (count_ff == CNT_W'(MAX_KEYS)) begin
                  rsp_status_in = ksrs_pkg::ST_FULL;
               end else begin
                  rsp_status_in = ksrs_pkg::ST_DONE;
                  wr_en         = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ksrs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ksrs_pkg::S_IDLE;
         count_ff     <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = (state_ff != ksrs_pkg::S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
